// ===== sv/wrd_pkg.sv =====
// Shared types and constants for the wide restoring divider.
// No dependencies; every other file of the block depends on this package.
package wrd_pkg;

  localparam int unsigned LimbW         = 64;
  localparam int unsigned DefLimbCount  = 16;

  typedef enum logic [1:0] {
    FUNC_LOAD_DIVIDEND = 2'd0,
    FUNC_LOAD_DIVISOR  = 2'd1,
    FUNC_START         = 2'd2,
    FUNC_UNUSED        = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [3:0]       limb_index;
    logic [LimbW-1:0] limb_value;
  } wrd_in_t;

  typedef struct packed {
    logic             is_remainder;
    logic [3:0]       out_index;
    logic [LimbW-1:0] out_value;
    logic             div_by_zero;
    logic             last;
  } wrd_out_t;

  // Status of one limb pass through the shift-subtract unit.
  typedef struct packed {
    logic shift_out;
    logic borrow;
  } alu_st_t;

endpackage

// ===== sv/wrd_if.sv =====
// Valid/ready channel interfaces for the divider's request and result streams.
// Depends on wrd_pkg for the payload types.
interface wrd_in_if;
  logic             valid;
  logic             ready;
  wrd_pkg::wrd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wrd_out_if;
  logic              valid;
  logic              ready;
  wrd_pkg::wrd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/wrd_limb_alu.sv =====
// One-limb shift-left and trial-subtract unit; carry and borrow ripple
// across limbs through registers. Depends on wrd_pkg.
module wrd_limb_alu (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     first_i,
  input  logic                     bit_i,
  input  logic [wrd_pkg::LimbW-1:0] rem_i,
  input  logic [wrd_pkg::LimbW-1:0] dsr_i,
  output logic [wrd_pkg::LimbW-1:0] shift_o,
  output logic [wrd_pkg::LimbW-1:0] trial_o,
  output wrd_pkg::alu_st_t          st_o
);
  import wrd_pkg::*;

  logic           carry_q, carry_d;
  logic           borrow_q, borrow_d;
  logic           cin, bin;
  logic [LimbW:0] diff;

  assign cin     = first_i ? bit_i : carry_q;
  assign bin     = first_i ? 1'b0 : borrow_q;
  assign shift_o = {rem_i[LimbW-2:0], cin};
  assign diff    = {1'b0, shift_o} - {1'b0, dsr_i} - {{LimbW{1'b0}}, bin};
  assign trial_o = diff[LimbW-1:0];
  assign carry_d  = rem_i[LimbW-1];
  assign borrow_d = diff[LimbW];
  assign st_o.shift_out = carry_d;
  assign st_o.borrow    = borrow_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q  <= 1'b0;
      borrow_q <= 1'b0;
    end else if (en_i) begin
      carry_q  <= carry_d;
      borrow_q <= borrow_d;
    end
  end
endmodule

// ===== sv/wide_restoring_divider.sv =====
// Unsigned divider for LIMB_COUNT x 64-bit operands; loads are accepted back to back.
// A start clears the accumulators and checks the divisor limb by limb, then runs
// LIMB_COUNT*64 quotient steps, each passing one limb per cycle through the shared
// shift-subtract unit; a zero divisor skips the steps. The 2*LIMB_COUNT result
// limbs then leave one per cycle, quotient first, slower when the sink stalls.
// Input is refused from the start transfer until the last result limb enters the
// output register; that limb may still wait there while the next request is taken.
module wide_restoring_divider #(
  parameter int unsigned LIMB_COUNT = wrd_pkg::DefLimbCount
) (
  input  logic clk_i,
  input  logic rst_ni,
  wrd_in_if.sink    req_i,
  wrd_out_if.source rsp_o
);
  import wrd_pkg::*;

  localparam int unsigned IW = (LIMB_COUNT > 1) ? $clog2(LIMB_COUNT) : 1;
  localparam int unsigned BW = IW + 6;
  localparam int unsigned KW = IW + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_STEP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [LimbW-1:0] dvd_q [LIMB_COUNT];
  logic [LimbW-1:0] dsr_q [LIMB_COUNT];
  logic [LimbW-1:0] quo_q [LIMB_COUNT];
  logic [LimbW-1:0] rem_q [2][LIMB_COUNT];

  logic          sel_q, dz_q, nz_q;
  logic [IW-1:0] li_q;
  logic [BW-1:0] bit_q;
  logic [KW-1:0] k_q;
  logic          ovalid_q;
  wrd_out_t      odata_q;

  logic          accept, load_ok, li_last, take, emit_go;
  logic [IW-1:0] load_idx, pos;
  logic          k_rem;
  logic          dvd_bit;
  logic [LimbW-1:0] shift_v, trial_v, emit_v;
  alu_st_t       st;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign load_ok     = 32'(req_i.data.limb_index) < LIMB_COUNT;
  assign load_idx    = IW'(req_i.data.limb_index);
  assign li_last     = (32'(li_q) == LIMB_COUNT - 1);
  assign dvd_bit     = dvd_q[bit_q[BW-1:6]][bit_q[5:0]];

  wrd_limb_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (state_q == ST_STEP),
    .first_i (li_q == '0),
    .bit_i   (dvd_bit),
    .rem_i   (rem_q[sel_q][li_q]),
    .dsr_i   (dsr_q[li_q]),
    .shift_o (shift_v),
    .trial_o (trial_v),
    .st_o    (st)
  );

  assign take = st.shift_out || !st.borrow;

  // Emission index: quotient limbs first, then remainder limbs.
  assign k_rem   = (32'(k_q) >= LIMB_COUNT);
  assign pos     = k_rem ? IW'(32'(k_q) - LIMB_COUNT) : IW'(k_q);
  assign emit_go = (state_q == ST_EMIT) && (!ovalid_q || rsp_o.ready);
  always_comb begin
    if (k_rem) begin
      emit_v = dz_q ? dvd_q[pos] : rem_q[sel_q][pos];
    end else begin
      emit_v = dz_q ? {LimbW{1'b1}} : quo_q[pos];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && req_i.data.func == FUNC_START) state_d = ST_SCAN;
      ST_SCAN: begin
        if (li_last) begin
          state_d = (nz_q || dsr_q[li_q] != '0) ? ST_STEP : ST_EMIT;
        end
      end
      ST_STEP: if (li_last && bit_q == '0) state_d = ST_EMIT;
      ST_EMIT: if (emit_go && 32'(k_q) == 2 * LIMB_COUNT - 1) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      sel_q    <= 1'b0;
      dz_q     <= 1'b0;
      nz_q     <= 1'b0;
      li_q     <= '0;
      bit_q    <= '0;
      k_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= emit_go || (ovalid_q && !rsp_o.ready);
      unique case (state_q)
        ST_IDLE: begin
          li_q  <= '0;
          nz_q  <= 1'b0;
          k_q   <= '0;
          bit_q <= BW'(LIMB_COUNT * 64 - 1);
        end
        ST_SCAN: begin
          nz_q <= nz_q || (dsr_q[li_q] != '0);
          li_q <= li_last ? '0 : li_q + 1'b1;
          if (li_last) dz_q <= !(nz_q || dsr_q[li_q] != '0);
        end
        ST_STEP: begin
          li_q <= li_last ? '0 : li_q + 1'b1;
          if (li_last) begin
            // Keep the trial difference when it did not underflow.
            if (take) sel_q <= !sel_q;
            bit_q <= bit_q - 1'b1;
          end
        end
        ST_EMIT: if (emit_go) k_q <= k_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && load_ok && req_i.data.func == FUNC_LOAD_DIVIDEND) begin
      dvd_q[load_idx] <= req_i.data.limb_value;
    end
    if (accept && load_ok && req_i.data.func == FUNC_LOAD_DIVISOR) begin
      dsr_q[load_idx] <= req_i.data.limb_value;
    end
    if (state_q == ST_SCAN) begin
      quo_q[li_q]        <= '0;
      rem_q[sel_q][li_q] <= '0;
    end
    if (state_q == ST_STEP) begin
      rem_q[sel_q][li_q]  <= shift_v;
      rem_q[!sel_q][li_q] <= trial_v;
      if (li_last && take) quo_q[bit_q[BW-1:6]][bit_q[5:0]] <= 1'b1;
    end
    if (emit_go) begin
      odata_q.is_remainder <= k_rem;
      odata_q.out_index    <= 4'(pos);
      odata_q.out_value    <= emit_v;
      odata_q.div_by_zero  <= dz_q;
      odata_q.last         <= (32'(k_q) == 2 * LIMB_COUNT - 1);
    end
  end

  assign rsp_o.valid = ovalid_q;
  assign rsp_o.data  = odata_q;
endmodule
